// ===== sv/sm4_block_cipher_ctr_core_assert.svh =====
// Assertion macros shared by the sm4 ctr checker.
`ifndef SM4_BLOCK_CIPHER_CTR_CORE_ASSERT_SVH
`define SM4_BLOCK_CIPHER_CTR_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define SM4CTR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sm4 ctr core: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define SM4CTR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sm4 ctr core: same-cycle check failed");

`endif

// ===== sv/sm4ctr_pkg.sv =====
// Package: SM4 constants, S-box, round helpers and control types.
package sm4ctr_pkg;

   localparam int ROUNDS   = 32;
   localparam int RND_W    = $clog2(ROUNDS);
   localparam int WORD_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int REQ_W    = 168;   // 165 field bits padded to whole bytes
   localparam int RSP_W    = 128;

   typedef enum logic [FUNC_W-1:0] {
      FN_LOAD_KEY = 2'd0,
      FN_ENCRYPT  = 2'd1,
      FN_LOAD_CTR = 2'd2,
      FN_CTR      = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             load_key;
      logic             load_ctr;
      logic             start_enc;
      logic             start_ctr;
      logic             round;
      logic             emit;
      logic [RND_W-1:0] key_addr;
   } cmd_type;

   localparam logic [0:255][7:0] SBOX = {
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Byte-wise S-box substitution.
   function automatic logic [WORD_W-1:0] sm4_tau(input logic [WORD_W-1:0] v);
      sm4_tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
      rotl = (v << n) | (v >> (WORD_W - n));
   endfunction

   // Linear diffusion L.
   function automatic logic [WORD_W-1:0] sm4_lin(input logic [WORD_W-1:0] b);
      sm4_lin = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
   endfunction

endpackage

// ===== sv/sm4ctr_ctrl.sv =====
// Controller: item decode, round counter and result handshake.
module sm4ctr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic [sm4ctr_pkg::FUNC_W-1:0] req_func,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output sm4ctr_pkg::cmd_type      cmd
);

   sm4ctr_pkg::state_type           state_ff, state_in;
   logic [sm4ctr_pkg::RND_W-1:0]    rnd_ff, rnd_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            accept;
   logic                            crypt;
   logic                            last_round;
   logic                            emit;

   assign accept     = req_tvalid && req_tready;
   assign crypt      = (req_func == sm4ctr_pkg::FN_ENCRYPT) || (req_func == sm4ctr_pkg::FN_CTR);
   assign last_round = (rnd_ff == sm4ctr_pkg::RND_W'(sm4ctr_pkg::ROUNDS - 1));
   assign emit       = (state_ff == sm4ctr_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sm4ctr_pkg::ST_IDLE: begin
            if (accept && crypt) state_in = sm4ctr_pkg::ST_ROUND;
         end
         sm4ctr_pkg::ST_ROUND: begin
            if (last_round) state_in = sm4ctr_pkg::ST_DONE;
         end
         sm4ctr_pkg::ST_DONE: begin
            if (emit) state_in = sm4ctr_pkg::ST_IDLE;
         end
         default: state_in = sm4ctr_pkg::ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      req_tready    = (state_ff == sm4ctr_pkg::ST_IDLE);
      rsp_tvalid    = rsp_valid_ff;
      cmd.load_key  = accept && (req_func == sm4ctr_pkg::FN_LOAD_KEY);
      cmd.load_ctr  = accept && (req_func == sm4ctr_pkg::FN_LOAD_CTR);
      cmd.start_enc = accept && (req_func == sm4ctr_pkg::FN_ENCRYPT);
      cmd.start_ctr = accept && (req_func == sm4ctr_pkg::FN_CTR);
      cmd.round     = (state_ff == sm4ctr_pkg::ST_ROUND);
      cmd.emit      = emit;
      // key read is registered: fetch the key of the following round
      cmd.key_addr  = cmd.round ? sm4ctr_pkg::RND_W'(rnd_ff + 1'b1) : '0;
      rnd_in        = cmd.round ? sm4ctr_pkg::RND_W'(rnd_ff + 1'b1) : '0;
      rsp_valid_in  = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sm4ctr_pkg::ST_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/sm4ctr_dp.sv =====
// Datapath: round-key memory, counter, round state and result register.
module sm4ctr_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  sm4ctr_pkg::cmd_type           cmd,
   input  logic [sm4ctr_pkg::RND_W-1:0]  key_index,
   input  logic [31:0]                   key_word,
   input  logic [63:0]                   data_hi,
   input  logic [63:0]                   data_lo,
   output logic [sm4ctr_pkg::RSP_W-1:0]  rsp_data
);

   logic [31:0]        key_mem [sm4ctr_pkg::ROUNDS];
   logic [31:0]        key_q_ff;
   logic [63:0]        ctr_hi_ff, ctr_hi_in;
   logic [63:0]        ctr_lo_ff, ctr_lo_in;
   logic [0:3][31:0]   x_ff, x_in;
   logic [127:0]       mask_ff, mask_in;
   logic [127:0]       rsp_ff, rsp_in;
   logic [31:0]        t_word;
   logic [31:0]        n_word;

   // round-key store, registered read
   always_ff @(posedge clock) begin
      if (cmd.load_key) key_mem[key_index] <= key_word;
      key_q_ff <= key_mem[cmd.key_addr];
   end

   assign t_word = x_ff[1] ^ x_ff[2] ^ x_ff[3] ^ key_q_ff;
   assign n_word = x_ff[0] ^ sm4ctr_pkg::sm4_lin(sm4ctr_pkg::sm4_tau(t_word));

   always_comb begin
      ctr_hi_in = ctr_hi_ff;
      ctr_lo_in = ctr_lo_ff;
      x_in      = x_ff;
      mask_in   = mask_ff;
      rsp_in    = rsp_ff;
      if (cmd.load_ctr) begin
         ctr_hi_in = data_hi;
         ctr_lo_in = data_lo;
      end
      if (cmd.start_enc) begin
         x_in    = {data_hi, data_lo};
         mask_in = '0;
      end
      if (cmd.start_ctr) begin
         x_in      = {ctr_hi_ff, ctr_lo_ff};
         mask_in   = {data_hi, data_lo};
         // only the low word counts; no carry upward
         ctr_lo_in = {ctr_lo_ff[63:32], 32'(ctr_lo_ff[31:0] + 1'b1)};
      end
      if (cmd.round) x_in = {x_ff[1], x_ff[2], x_ff[3], n_word};
      if (cmd.emit)  rsp_in = {x_ff[3], x_ff[2], x_ff[1], x_ff[0]} ^ mask_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_hi_ff <= '0;
         ctr_lo_ff <= '0;
      end else begin
         ctr_hi_ff <= ctr_hi_in;
         ctr_lo_ff <= ctr_lo_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      mask_ff <= mask_in;
      rsp_ff  <= rsp_in;
   end

   // result_hi in the low half of tdata, result_lo above it
   assign rsp_data = {rsp_ff[63:0], rsp_ff[127:64]};

endmodule

// ===== sv/sm4_block_cipher_ctr_core.sv =====
// Top level: SM4 block cipher engine with 32-bit counter mode.
//
// Input channel req_*: one item per handshake. req_tuser carries the
// operation (load round key, encrypt block, load counter, ctr block);
// req_tdata carries key_index, key_word, data_hi, data_lo.
// Result channel rsp_*: one item per encrypt or ctr item, none for loads.
//
// Loads take effect at the accepting edge; a load can be accepted every
// cycle while no cipher item is in progress. An encrypt or ctr item runs
// 32 rounds, one per cycle through a single shared round function, keys
// read from a 32-word register file. Its result is loaded into the output
// register in ST_DONE after the last round, and the next item can be
// accepted as soon as it is loaded; no new item is taken before then.
// A finished result sits in an output register; req_tready returns as
// soon as it is loaded, so a stalled receiver only blocks the next cipher
// item once a second result is ready to be written.
// Reset clears the counter to zero and the control state; round keys are
// undefined until loaded.
module sm4_block_cipher_ctr_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [4:0] key_index, [36:5] key_word, [100:37] data_hi, [164:101] data_lo
   input  logic [sm4ctr_pkg::REQ_W-1:0]  req_tdata,
   // [1:0] func
   input  logic [sm4ctr_pkg::FUNC_W-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [63:0] result_hi, [127:64] result_lo
   output logic [sm4ctr_pkg::RSP_W-1:0]  rsp_tdata
);

   sm4ctr_pkg::cmd_type cmd;

   sm4ctr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // the padding bits [167:165] of req_tdata carry nothing
   sm4ctr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .key_index (req_tdata[4:0]),
      .key_word  (req_tdata[36:5]),
      .data_hi   (req_tdata[100:37]),
      .data_lo   (req_tdata[164:101]),
      .rsp_data  (rsp_tdata)
   );

endmodule

// ===== sv/sm4ctr_checker.sv =====
// Port-level checker for the sm4 ctr core, bound to the top level.
`include "sm4_block_cipher_ctr_core_assert.svh"

module sm4ctr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [sm4ctr_pkg::FUNC_W-1:0] req_tuser,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [sm4ctr_pkg::RSP_W-1:0]  rsp_tdata
);

   logic req_acc;
   logic cipher_op;

   assign req_acc   = req_tvalid && req_tready;
   // encrypt and ctr items produce a result, loads do not
   assign cipher_op = (req_tuser == sm4ctr_pkg::FN_ENCRYPT) || (req_tuser == sm4ctr_pkg::FN_CTR);

   `SM4CTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SM4CTR_ASSERT_NEXT(a_cipher_busy, clock, reset, req_acc && cipher_op, !req_tready)
   `SM4CTR_ASSERT_NEXT(a_load_ready, clock, reset, req_acc && !cipher_op, req_tready)
   `SM4CTR_ASSERT_NEXT(a_load_no_rsp, clock, reset, req_acc && !cipher_op && !rsp_tvalid, !rsp_tvalid)
   `SM4CTR_ASSERT_SAME(a_no_rsp_on_accept, clock, reset, req_acc && cipher_op && !rsp_tvalid, !$rose(rsp_tvalid))

endmodule

bind sm4_block_cipher_ctr_core sm4ctr_checker u_sm4ctr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/sm4_block_cipher_ctr_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the SM4 counter-mode engine: directed and random items, results checked in order.
module sm4_block_cipher_ctr_core_tb;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int RANDOM_ITEMS   = 850;
   localparam int MAX_GAP        = 13;
   // Wait after draining so that a stray result can still show up before the verdict.
   localparam int SETTLE_CYCLES  = 40;
   localparam int TIMEOUT_NS     = 15_000_000;
   localparam int REQ_FIELD_BITS = 165;   // key_index + key_word + data_hi + data_lo

   // Standard SM4 substitution table, kept here so the check does not lean on the design's copy.
   localparam logic [0:255][7:0] CIPHER_SBOX = {
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Mirror of the engine: round keys, counter and the ciphertext blocks still owed.
   // Blocks are held with the first eight bytes in the upper half.
   class sm4_engine_mirror;
      logic [31:0]  round_key [32];
      logic [63:0]  ctr_upper;
      logic [63:0]  ctr_lower;
      logic [127:0] due_blocks [$];
      int           mismatches;

      function new();
         ctr_upper  = '0;
         ctr_lower  = '0;
         mismatches = 0;
      endfunction

      function logic [31:0] rol(input logic [31:0] w, input int n);
         logic [63:0] dbl;
         dbl = {w, w};
         return dbl[63-n -: 32];
      endfunction

      // T transform: byte substitution followed by the linear mix.
      function logic [31:0] round_mix(input logic [31:0] t);
         logic [31:0] s;
         for (int b = 0; b < 4; b++) s[8*b +: 8] = CIPHER_SBOX[t[8*b +: 8]];
         return s ^ rol(s, 2) ^ rol(s, 10) ^ rol(s, 18) ^ rol(s, 24);
      endfunction

      function logic [127:0] sm4_cipher(input logic [63:0] hi, input logic [63:0] lo);
         logic [31:0] x0, x1, x2, x3, nx;
         {x0, x1, x2, x3} = {hi, lo};
         for (int r = 0; r < 32; r++) begin
            nx = x0 ^ round_mix(x1 ^ x2 ^ x3 ^ round_key[r]);
            x0 = x1;
            x1 = x2;
            x2 = x3;
            x3 = nx;
         end
         return {x3, x2, x1, x0};   // final words come out reversed
      endfunction

      function void note_item(input sm4ctr_pkg::func_type fn, input logic [4:0] idx,
                              input logic [31:0] kw,
                              input logic [63:0] hi, input logic [63:0] lo);
         logic [127:0] blk;
         case (fn)
            sm4ctr_pkg::FN_LOAD_KEY: round_key[idx] = kw;
            sm4ctr_pkg::FN_ENCRYPT: begin
               blk = sm4_cipher(hi, lo);
               due_blocks.push_back(blk);
            end
            sm4ctr_pkg::FN_LOAD_CTR: begin
               ctr_upper = hi;
               ctr_lower = lo;
            end
            default: begin
               blk = sm4_cipher(ctr_upper, ctr_lower) ^ {hi, lo};
               due_blocks.push_back(blk);
               // only the low word counts, no carry out of it
               ctr_lower[31:0] = ctr_lower[31:0] + 32'd1;
            end
         endcase
      endfunction

      function void check_result(input logic [sm4ctr_pkg::RSP_W-1:0] tdata);
         logic [127:0] want;
         if (due_blocks.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, tdata);
            mismatches++;
            return;
         end
         want = due_blocks.pop_front();
         if (tdata[63:0] !== want[127:64]) begin
            $display("%0t: result_hi expected %h actual %h", $time, want[127:64], tdata[63:0]);
            mismatches++;
         end
         if (tdata[127:64] !== want[63:0]) begin
            $display("%0t: result_lo expected %h actual %h", $time, want[63:0], tdata[127:64]);
            mismatches++;
         end
      endfunction
   endclass

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [sm4ctr_pkg::REQ_W-1:0]  req_tdata  = '0;
   logic [sm4ctr_pkg::FUNC_W-1:0] req_tuser  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [sm4ctr_pkg::RSP_W-1:0]  rsp_tdata;

   // When set, both sides run back to back; toggled now and then by the sender.
   bit quiet = 1'b0;

   sm4_engine_mirror mirror = new();

   sm4_block_cipher_ctr_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one item after a random gap and hold it until the engine takes it.
   // Valid stays high on return so back-to-back items never drop it for a step.
   task automatic send_item(input sm4ctr_pkg::func_type fn, input logic [4:0] idx,
                            input logic [31:0] kw,
                            input logic [63:0] hi, input logic [63:0] lo);
      int gap;
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {{(sm4ctr_pkg::REQ_W-REQ_FIELD_BITS){1'b0}}, lo, hi, kw, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mirror.note_item(fn, idx, kw, hi, lo);
   endtask

   // Stop offering and wait until every owed block has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mirror.due_blocks.size() != 0) @(posedge clock);
   endtask

   // Result side: random stall before each item, sampled on the handshake edge.
   initial begin : result_sink
      int stall;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         mirror.check_result(rsp_tdata);
      end
   end

   initial begin : stimulus
      sm4ctr_pkg::func_type fn;
      logic [31:0]          kw;
      logic [63:0]          hi, lo;
      int                   pick;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Every round key gets written before any cipher item, key words at both extremes.
      // The unused data fields carry noise that must be ignored.
      for (int k = 0; k < 32; k++) begin
         kw = (k == 0) ? 32'h0 : (k == 31) ? 32'hFFFF_FFFF : $urandom;
         send_item(sm4ctr_pkg::FN_LOAD_KEY, 5'(k), kw, rand64(), rand64());
      end

      // Plain blocks at the extremes; key fields set but unused.
      send_item(sm4ctr_pkg::FN_ENCRYPT, 5'h1F, 32'hFFFF_FFFF, '0, '0);
      send_item(sm4ctr_pkg::FN_ENCRYPT, 5'h00, 32'h0, '1, '1);
      send_item(sm4ctr_pkg::FN_ENCRYPT, 5'h0A, $urandom,
                64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);

      // Counter straight out of reset is all zero.
      send_item(sm4ctr_pkg::FN_CTR, 5'h15, $urandom, '0, '0);

      // Counter two steps short of wrapping: low word runs ...FE, ...FF, then back to 0
      // while the upper 96 bits stay all ones.
      send_item(sm4ctr_pkg::FN_LOAD_CTR, 5'h1F, 32'hFFFF_FFFF, '1, 64'hFFFF_FFFF_FFFF_FFFE);
      send_item(sm4ctr_pkg::FN_CTR, 5'h00, 32'h0, '1, '1);
      send_item(sm4ctr_pkg::FN_CTR, 5'h07, $urandom, rand64(), rand64());
      send_item(sm4ctr_pkg::FN_CTR, 5'h1F, $urandom, '0, '0);

      // Hold off until the engine is empty, then swap the extreme keys and encrypt again.
      wait_drained();
      send_item(sm4ctr_pkg::FN_LOAD_KEY, 5'd0, 32'hFFFF_FFFF, '1, '1);
      send_item(sm4ctr_pkg::FN_LOAD_KEY, 5'd31, 32'h0, '0, '0);
      send_item(sm4ctr_pkg::FN_ENCRYPT, 5'h11, $urandom, rand64(), rand64());

      // Random mix, heavy on cipher items. Counter loads often land near the
      // wrap point so the low-word rollover gets hit repeatedly.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         fn = (pick < 15) ? sm4ctr_pkg::FN_LOAD_KEY :
              (pick < 55) ? sm4ctr_pkg::FN_ENCRYPT :
              (pick < 63) ? sm4ctr_pkg::FN_LOAD_CTR : sm4ctr_pkg::FN_CTR;
         hi = rand64();
         lo = rand64();
         if (fn == sm4ctr_pkg::FN_LOAD_CTR && $urandom_range(0, 2) == 0)
            lo[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 4);
         send_item(fn, 5'($urandom_range(0, 31)), $urandom, hi, lo);
         if (n == RANDOM_ITEMS / 2) wait_drained();
      end

      // Drain, then leave room for any stray result to show up.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

endmodule
